FILE: rtl/esd_pkg.sv
// Shared types, character constants and lookup functions of the escape
// sequence byte decoder. No dependencies.
package esd_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_ONE       = 8'h31;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] BYTE_NUL       = 8'h00;

  // Depth of the result queue in front of the output port.
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned CountWidth  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IndexWidth  = $clog2(QUEUE_DEPTH);

  // Decoder modes, one-hot.
  typedef enum logic [3:0] {
    MODE_PLAIN = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_ZERO  = 4'b0100,
    MODE_HEX1  = 4'b1000
  } esd_mode_e;

  // One result byte with its end marks.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       message_last;
  } esd_item_t;

  // Everything one input character produces: zero, one or two bytes.
  typedef struct packed {
    logic [1:0] count;
    esd_item_t  first;
    esd_item_t  second;
  } esd_pair_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    begin
      case (c) inside
        [8'h30:8'h39]:                r = {1'b1, c[3:0]};
        [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
        default:                      r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // Bit 8 flags a known escape letter, bits 7:0 carry the control byte.
  function automatic logic [8:0] control_byte(logic [7:0] c);
    logic [8:0] r;
    begin
      case (c)
        8'h61:          r = {1'b1, 8'h07}; // a
        8'h62:          r = {1'b1, 8'h08}; // b
        8'h74:          r = {1'b1, 8'h09}; // t
        8'h6E:          r = {1'b1, 8'h0A}; // n
        8'h76:          r = {1'b1, 8'h0B}; // v
        8'h66:          r = {1'b1, 8'h0C}; // f
        8'h72:          r = {1'b1, 8'h0D}; // r
        CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
        default:        r = 9'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/esd_decoder.sv
// Escape decoder: mode and held-nibble registers plus the logic that turns
// one character into up to two result bytes. Depends on esd_pkg.
module esd_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_in_i,
  input  logic             text_end_i,
  output esd_pkg::esd_pair_t pair_o
);
  import esd_pkg::*;

  esd_mode_e  mode_q, mode_d;
  logic [3:0] nibble_q, nibble_d;

  logic [4:0] hv;
  logic [8:0] cb;
  logic [1:0] n;
  logic [7:0] b0, b1;

  always_comb begin
    hv       = hex_value(char_in_i);
    cb       = control_byte(char_in_i);
    mode_d   = MODE_PLAIN;
    nibble_d = nibble_q;
    n        = 2'd0;
    b0       = char_in_i;
    b1       = char_in_i;
    case (mode_q)
      MODE_PLAIN: begin
        if (char_in_i == CHAR_BACKSLASH && !text_end_i) begin
          mode_d = MODE_ESC;
        end else begin
          n = 2'd1;
        end
      end
      MODE_ESC: begin
        if (char_in_i == CHAR_ZERO) begin
          mode_d = MODE_ZERO;
        end else if (char_in_i >= CHAR_ONE && char_in_i <= CHAR_NINE) begin
          nibble_d = char_in_i[3:0];
          mode_d   = MODE_HEX1;
        end else if (cb[8]) begin
          n  = 2'd1;
          b0 = cb[7:0];
        end else begin
          n  = 2'd2;
          b0 = CHAR_BACKSLASH;
        end
      end
      MODE_ZERO, MODE_HEX1: begin
        if (hv[4] && mode_q == MODE_ZERO) begin
          nibble_d = hv[3:0];
          mode_d   = MODE_HEX1;
        end else if (hv[4]) begin
          n  = 2'd1;
          b0 = {nibble_q, hv[3:0]};
        end else begin
          // The escape ends here; the character is then decoded as plain text.
          b0 = (mode_q == MODE_ZERO) ? BYTE_NUL : {4'h0, nibble_q};
          if (char_in_i == CHAR_BACKSLASH && !text_end_i) begin
            n      = 2'd1;
            mode_d = MODE_ESC;
          end else begin
            n = 2'd2;
          end
        end
      end
      default: begin
        n = 2'd1;
      end
    endcase

    // At the end of the text a pending escape is flushed as one byte.
    if (text_end_i) begin
      if (mode_d == MODE_ZERO) begin
        n  = 2'd1;
        b0 = BYTE_NUL;
      end else if (mode_d == MODE_HEX1) begin
        n  = 2'd1;
        b0 = {4'h0, nibble_d};
      end
      mode_d   = MODE_PLAIN;
      nibble_d = 4'h0;
    end

    pair_o.count               = n;
    pair_o.first.data          = b0;
    pair_o.first.run_last      = (n == 2'd1);
    pair_o.first.message_last  = (n == 2'd1) && text_end_i;
    pair_o.second.data         = b1;
    pair_o.second.run_last     = 1'b1;
    pair_o.second.message_last = text_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PLAIN;
      nibble_q <= 4'h0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      nibble_q <= nibble_d;
    end
  end

endmodule

FILE: rtl/esd_out_queue.sv
// Small result queue; takes up to two bytes per transfer, gives one byte
// per cycle on a valid/ready port while ready is high. Depends on esd_pkg.
module esd_out_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  esd_pkg::esd_pair_t             pair_i,
  output logic                           space_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output esd_pkg::esd_item_t             head_o,
  output logic [esd_pkg::CountWidth-1:0] count_o
);
  import esd_pkg::*;

  esd_item_t              entry_q [QUEUE_DEPTH];
  esd_item_t              entry_d [QUEUE_DEPTH];
  logic [CountWidth-1:0]  cnt_q, cnt_d, base;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = entry_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a full pair is required before a character is taken.
  assign space_o     = (cnt_q <= CountWidth'(QUEUE_DEPTH - 2));
  assign count_o     = cnt_q;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) begin
        entry_d[i] = entry_q[i + 1];
      end else begin
        entry_d[i] = entry_q[i];
      end
    end
    entry_d[QUEUE_DEPTH - 1] = entry_q[QUEUE_DEPTH - 1];
    base  = cnt_q - CountWidth'(pop);
    cnt_d = base;
    if (push_i) begin
      if (pair_i.count != 2'd0) begin
        entry_d[base[IndexWidth-1:0]] = pair_i.first;
      end
      if (pair_i.count == 2'd2) begin
        entry_d[base[IndexWidth-1:0] + IndexWidth'(1)] = pair_i.second;
      end
      cnt_d = base + CountWidth'(pair_i.count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

endmodule

FILE: rtl/escape_sequence_byte_decoder_core.sv
// Top level of the escape sequence byte decoder: character input channel,
// decoder and result queue. Depends on esd_pkg, esd_decoder, esd_out_queue.
//
// Usage:
//   Characters of a macro text arrive one per transfer on the input channel
//   (char_in_i, text_end_i, in_valid_i / in_ready_o). text_end_i marks the
//   last character; any escape still open is then flushed.
//   Decoded bytes leave one per transfer on the output channel (byte_out_o,
//   run_last_o, message_last_o, out_valid_o / out_ready_i). run_last_o marks
//   the last byte caused by one character, message_last_o the final byte of
//   the text.
// Timing and rate:
//   A character is decoded in the cycle it is transferred and its bytes are
//   written to a three-entry result queue; with the queue empty, the first
//   byte is visible in the cycle after the input transfer. The output port
//   moves one byte per cycle while out_ready_i is high, which sets the rate;
//   a character that gives two bytes holds the output longer than one that
//   gives one byte, and one that only opens an escape produces nothing.
// Reset and stalls:
//   Reset empties the queue and returns the decoder to plain text mode.
//   The input is taken while the queue has room for two bytes, so one
//   waiting byte does not block the next character; a longer stall at the
//   output fills the queue and then holds off the input.
module escape_sequence_byte_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       run_last_o,
  output logic       message_last_o
);
  import esd_pkg::*;

  logic                  accept;
  esd_pair_t             pair;
  esd_item_t             head;
  logic                  space;
  logic [CountWidth-1:0] count;

  assign in_ready_o = space;
  assign accept     = in_valid_i && in_ready_o;

  // Mode and held hex digit advance only on an input transfer.
  esd_decoder u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_in_i  (char_in_i),
    .text_end_i (text_end_i),
    .pair_o     (pair)
  );

  // The queue separates the output handshake from the input side.
  esd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .pair_i      (pair),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head),
    .count_o     (count)
  );

  assign byte_out_o     = head.data;
  assign run_last_o     = head.run_last;
  assign message_last_o = head.message_last;

  // The last character of a text always yields at least one byte.
  a_end_gives_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && text_end_i |=> out_valid_o)
    else $error("no byte after the last character of a text");

  // The end of the message is always the end of a character's run.
  a_message_last_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_last_o |-> run_last_o)
    else $error("message end without run end");

  // An empty queue always takes the next character.
  a_empty_takes_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count == '0 |-> in_ready_o)
    else $error("input held off with an empty queue");

  // The queue never holds more than its depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CountWidth'(QUEUE_DEPTH))
    else $error("result queue overflow");

endmodule
